[rtl/assert_macros.svh]
// assertion macros used by the rtl core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");

`define ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`else

`define ASSERT_IMP(label, ante, cons)

`define ASSERT_NXT(label, ante, cons)

`endif

`endif

[rtl/rsi_pkg.sv]
// widths, register indexes and constants of the ray / sphere intersection core
package rsi_pkg;

  localparam int COORD_W   = 32;
  localparam int FRAC_BITS = 16;
  localparam int DIR_W     = 18;
  localparam int RADIUS_W  = 31;
  localparam int CFG_W     = 32;
  localparam int IDX_W     = 2;

  localparam logic [IDX_W-1:0] REG_CENTER_X = 2'd0;
  localparam logic [IDX_W-1:0] REG_CENTER_Y = 2'd1;
  localparam logic [IDX_W-1:0] REG_CENTER_Z = 2'd2;
  localparam logic [IDX_W-1:0] REG_RADIUS   = 2'd3;

  localparam logic [RADIUS_W-1:0] RADIUS_RESET = RADIUS_W'(1) << FRAC_BITS;

  localparam int S_W   = COORD_W + 1;
  localparam int SDP_W = S_W + DIR_W;
  localparam int SD_W  = SDP_W + 2;
  localparam int SQ_W  = 2 * S_W;
  localparam int SS_W  = SQ_W + 2;
  localparam int RR_W  = 2 * RADIUS_W;
  localparam int K_W   = SS_W + 1;

  localparam int LO_W  = (SD_W + 1) / 2;
  localparam int HI_W  = SD_W - LO_W;
  localparam int HH_W  = 2 * HI_W;
  localparam int HL_W  = HI_W + LO_W;
  localparam int LL_W  = 2 * LO_W;
  localparam int SQSD_W = 2 * SD_W;

  localparam int DISC_W = ((SQSD_W > K_W + 2 * FRAC_BITS) ? SQSD_W : K_W + 2 * FRAC_BITS) + 1;
  localparam int ROOT_W = DISC_W / 2;
  localparam int REM_W  = 2 * ROOT_W;

  localparam int T_W  = ((SD_W > ROOT_W) ? SD_W : ROOT_W) + 2;
  localparam int TQ_W = T_W - FRAC_BITS;

  // edges from the accepting edge to the edge that raises done
  localparam int PIPE_LAT = ROOT_W + 8;

  localparam logic signed [COORD_W-1:0] MISS_DIST = -(COORD_W'(1) <<< FRAC_BITS);
  localparam logic signed [COORD_W-1:0] SAT_MAX   = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic signed [COORD_W-1:0] SAT_MIN   = {1'b1, {(COORD_W-1){1'b0}}};

endpackage

[rtl/ray_sphere_intersect_core.sv]
// ray / sphere intersection core: pipelined dot products, discriminant, square root, root pick
//
// Fully pipelined: a new ray request is taken on every clock while busy is low, and its
// result shows up as a one-cycle done pulse, with requests leaving in the order they came.
// The latency is fixed and is set by the 53-stage bit-per-stage square root pipeline behind
// seven stages of dot products, squaring and discriminant assembly. The receiver cannot
// stall: every done pulse must be taken in its cycle. busy is high during reset and in the
// cycle after it. Sphere center and radius are written through cfg_write/cfg_index/cfg_data
// and must only change while no request is in flight; hit_distance is -1.0 and missed is
// high for a ray that misses.
`include "assert_macros.svh"

module ray_sphere_intersect_core (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [rsi_pkg::COORD_W-1:0]   origin_x,
  input  logic signed [rsi_pkg::COORD_W-1:0]   origin_y,
  input  logic signed [rsi_pkg::COORD_W-1:0]   origin_z,
  input  logic signed [rsi_pkg::DIR_W-1:0]     dir_x,
  input  logic signed [rsi_pkg::DIR_W-1:0]     dir_y,
  input  logic signed [rsi_pkg::DIR_W-1:0]     dir_z,
  output logic                                 done,
  output logic signed [rsi_pkg::COORD_W-1:0]   hit_distance,
  output logic                                 missed,
  input  logic                                 cfg_write,
  input  logic        [rsi_pkg::IDX_W-1:0]     cfg_index,
  input  logic        [rsi_pkg::CFG_W-1:0]     cfg_data
);

  localparam int ROOT_W = rsi_pkg::ROOT_W;

  // configuration
  logic signed [rsi_pkg::COORD_W-1:0]  center [3];
  logic        [rsi_pkg::RADIUS_W-1:0] radius;

  always_ff @(posedge clk) begin
    if (rst) begin
      center[0] <= '0;
      center[1] <= '0;
      center[2] <= '0;
      radius    <= rsi_pkg::RADIUS_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        rsi_pkg::REG_CENTER_X: center[0] <= cfg_data[rsi_pkg::COORD_W-1:0];
        rsi_pkg::REG_CENTER_Y: center[1] <= cfg_data[rsi_pkg::COORD_W-1:0];
        rsi_pkg::REG_CENTER_Z: center[2] <= cfg_data[rsi_pkg::COORD_W-1:0];
        rsi_pkg::REG_RADIUS:   radius    <= cfg_data[rsi_pkg::RADIUS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    busy <= rst;
  end

  logic accept;
  assign accept = start && !busy;

  logic signed [rsi_pkg::COORD_W-1:0] org [3];
  logic signed [rsi_pkg::DIR_W-1:0]   dir [3];

  assign org[0] = origin_x;
  assign org[1] = origin_y;
  assign org[2] = origin_z;
  assign dir[0] = dir_x;
  assign dir[1] = dir_y;
  assign dir[2] = dir_z;

  // stage 1: s = center - origin
  logic                             v1;
  logic signed [rsi_pkg::S_W-1:0]   s1 [3];
  logic signed [rsi_pkg::DIR_W-1:0] d1 [3];

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      s1[i] <= rsi_pkg::S_W'(center[i]) - rsi_pkg::S_W'(org[i]);
      d1[i] <= dir[i];
    end
  end

  // stage 2: products s*d, s*s and r*r
  logic                             v2;
  logic signed [rsi_pkg::SDP_W-1:0] sdp2 [3];
  logic signed [rsi_pkg::SQ_W-1:0]  sq2  [3];
  logic        [rsi_pkg::RR_W-1:0]  rr2;

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      sdp2[i] <= rsi_pkg::SDP_W'(s1[i]) * rsi_pkg::SDP_W'(d1[i]);
      sq2[i]  <= rsi_pkg::SQ_W'(s1[i]) * rsi_pkg::SQ_W'(s1[i]);
    end
    rr2 <= rsi_pkg::RR_W'(radius) * rsi_pkg::RR_W'(radius);
  end

  // stage 3: sums
  logic                            v3;
  logic signed [rsi_pkg::SD_W-1:0] sd3;
  logic signed [rsi_pkg::SS_W-1:0] ss3;
  logic        [rsi_pkg::RR_W-1:0] rr3;

  always_ff @(posedge clk) begin
    sd3 <= rsi_pkg::SD_W'(sdp2[0]) + rsi_pkg::SD_W'(sdp2[1]) + rsi_pkg::SD_W'(sdp2[2]);
    ss3 <= rsi_pkg::SS_W'(sq2[0]) + rsi_pkg::SS_W'(sq2[1]) + rsi_pkg::SS_W'(sq2[2]);
    rr3 <= rr2;
  end

  // stage 4: |sd| and r*r - s.s
  logic                            v4;
  logic signed [rsi_pkg::SD_W-1:0] sd4;
  logic        [rsi_pkg::SD_W-1:0] mag4;
  logic signed [rsi_pkg::K_W-1:0]  k4;

  always_ff @(posedge clk) begin
    sd4  <= sd3;
    mag4 <= sd3[rsi_pkg::SD_W-1] ? rsi_pkg::SD_W'(-sd3) : rsi_pkg::SD_W'(sd3);
    k4   <= rsi_pkg::K_W'($signed({1'b0, rr3})) - rsi_pkg::K_W'(ss3);
  end

  // stage 5: partial products of sd*sd
  logic                            v5;
  logic        [rsi_pkg::HI_W-1:0] mag_hi;
  logic        [rsi_pkg::LO_W-1:0] mag_lo;
  logic        [rsi_pkg::HH_W-1:0] hh5;
  logic        [rsi_pkg::HL_W-1:0] hl5;
  logic        [rsi_pkg::LL_W-1:0] ll5;
  logic signed [rsi_pkg::SD_W-1:0] sd5;
  logic signed [rsi_pkg::K_W-1:0]  k5;

  assign mag_hi = mag4[rsi_pkg::SD_W-1:rsi_pkg::LO_W];
  assign mag_lo = mag4[rsi_pkg::LO_W-1:0];

  always_ff @(posedge clk) begin
    hh5 <= rsi_pkg::HH_W'(mag_hi) * rsi_pkg::HH_W'(mag_hi);
    hl5 <= rsi_pkg::HL_W'(mag_hi) * rsi_pkg::HL_W'(mag_lo);
    ll5 <= rsi_pkg::LL_W'(mag_lo) * rsi_pkg::LL_W'(mag_lo);
    sd5 <= sd4;
    k5  <= k4;
  end

  // stage 6: sd*sd
  logic                              v6;
  logic        [rsi_pkg::SQSD_W-1:0] sum6;
  logic signed [rsi_pkg::SD_W-1:0]   sd6;
  logic signed [rsi_pkg::K_W-1:0]    k6;

  always_ff @(posedge clk) begin
    sum6 <= rsi_pkg::SQSD_W'({hh5, ll5})
          + (rsi_pkg::SQSD_W'(hl5) << (rsi_pkg::LO_W + 1));
    sd6  <= sd5;
    k6   <= k5;
  end

  // stage 7: discriminant, loaded into the root pipeline
  logic signed [rsi_pkg::DISC_W-1:0] disc;
  assign disc = rsi_pkg::DISC_W'($signed({1'b0, sum6}))
              + (rsi_pkg::DISC_W'(k6) <<< (2 * rsi_pkg::FRAC_BITS));

  logic                             rt_vld  [ROOT_W+1];
  logic                             rt_miss [ROOT_W+1];
  logic        [rsi_pkg::REM_W-1:0] rt_rem  [ROOT_W+1];
  logic        [ROOT_W-1:0]         rt_root [ROOT_W+1];
  logic signed [rsi_pkg::SD_W-1:0]  rt_sd   [ROOT_W+1];

  always_ff @(posedge clk) begin
    rt_miss[0] <= disc[rsi_pkg::DISC_W-1];
    rt_rem[0]  <= disc[rsi_pkg::DISC_W-1] ? '0
                : rsi_pkg::REM_W'(disc[rsi_pkg::DISC_W-2:0]);
    rt_root[0] <= '0;
    rt_sd[0]   <= sd6;
  end

  // one root bit per stage, most significant first
  for (genvar g = 0; g < ROOT_W; g++) begin : g_root
    localparam int B = ROOT_W - 1 - g;
    logic [rsi_pkg::REM_W-1:0] trial;
    logic                      fits;

    assign trial = (rsi_pkg::REM_W'(rt_root[g]) << (B + 1))
                 | (rsi_pkg::REM_W'(1) << (2 * B));
    assign fits  = rt_rem[g] >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        rt_vld[g+1] <= 1'b0;
      end else begin
        rt_vld[g+1] <= rt_vld[g];
      end
      rt_miss[g+1] <= rt_miss[g];
      rt_rem[g+1]  <= fits ? rt_rem[g] - trial : rt_rem[g];
      rt_root[g+1] <= fits ? (rt_root[g] | (ROOT_W'(1) << B)) : rt_root[g];
      rt_sd[g+1]   <= rt_sd[g];
    end
  end

  // roots p1 = sd - sqrt, p2 = sd + sqrt
  logic signed [rsi_pkg::T_W-1:0] sd_ext;
  logic signed [rsi_pkg::T_W-1:0] root_ext;
  logic                           vp;
  logic                           miss_p;
  logic signed [rsi_pkg::T_W-1:0] p1;
  logic signed [rsi_pkg::T_W-1:0] p2;

  assign sd_ext   = rsi_pkg::T_W'(rt_sd[ROOT_W]);
  assign root_ext = rsi_pkg::T_W'(rt_root[ROOT_W]);

  always_ff @(posedge clk) begin
    miss_p <= rt_miss[ROOT_W];
    p1     <= sd_ext - root_ext;
    p2     <= sd_ext + root_ext;
  end

  // pick root (p2 >= p1 always), floor to Q16.16, saturate
  logic signed [rsi_pkg::T_W-1:0]               t_pick;
  logic signed [rsi_pkg::TQ_W-1:0]              t_q;
  logic        [rsi_pkg::TQ_W-rsi_pkg::COORD_W:0] t_top;
  logic signed [rsi_pkg::COORD_W-1:0]           t_sat;

  assign t_pick = p1[rsi_pkg::T_W-1] ? p2 : p1;
  assign t_q    = t_pick[rsi_pkg::T_W-1:rsi_pkg::FRAC_BITS];
  assign t_top  = t_q[rsi_pkg::TQ_W-1:rsi_pkg::COORD_W-1];
  assign t_sat  = ((&t_top) || !(|t_top)) ? t_q[rsi_pkg::COORD_W-1:0]
                : (t_q[rsi_pkg::TQ_W-1] ? rsi_pkg::SAT_MIN : rsi_pkg::SAT_MAX);

  always_ff @(posedge clk) begin
    hit_distance <= miss_p ? rsi_pkg::MISS_DIST : t_sat;
    missed       <= miss_p;
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      v5        <= 1'b0;
      v6        <= 1'b0;
      rt_vld[0] <= 1'b0;
      vp        <= 1'b0;
      done      <= 1'b0;
    end else begin
      v1        <= accept;
      v2        <= v1;
      v3        <= v2;
      v4        <= v3;
      v5        <= v4;
      v6        <= v5;
      rt_vld[0] <= v6;
      vp        <= rt_vld[ROOT_W];
      done      <= vp;
    end
  end

  // floor square root leaves a remainder no larger than twice the root
  `ASSERT_IMP(a_root_floor, rt_vld[ROOT_W], ({1'b0, rt_rem[ROOT_W]} <= ({rt_root[ROOT_W], 1'b0})))
  `ASSERT_IMP(a_fixed_latency, done, $past(accept, rsi_pkg::PIPE_LAT + 1))
  `ASSERT_IMP(a_miss_value, done && missed, hit_distance == rsi_pkg::MISS_DIST)
  `ASSERT_NXT(a_no_drop, rt_vld[0], rt_vld[1])

endmodule
